FILE: hdl/icr_pkg.sv
// Shared types and constants for the impulse collision response unit.
// Used by icr_div_cell and impulse_collision_response_unit; no dependencies.
package icr_pkg;

	localparam int VEL_W  = 32;
	localparam int NRM_W  = 16;
	localparam int DEN_W  = 33;
	localparam int Q_W    = 25;   // weight quotient, up to 2^24 inclusive
	localparam int NUM_W  = DEN_W + Q_W - 1;
	localparam int G_W    = 38;
	localparam int CELLS  = Q_W;
	localparam logic [Q_W-1:0] W_ONE  = Q_W'(1) << 24;
	localparam logic [Q_W-1:0] W_HALF = Q_W'(1) << 23;
	localparam logic [16:0] RESTITUTION_RESET = 17'h10000;

	typedef struct packed {
		logic [2:0][VEL_W-1:0] va;
		logic [2:0][VEL_W-1:0] vb;
		logic [2:0][NRM_W-1:0] n;
		logic [G_W-1:0]        g;
		logic                  applied;
		logic                  den_zero;
	} job_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   bits;
		logic [Q_W-1:0]   quo;
		logic [DEN_W-1:0] den;
		job_t             job;
	} div_t;

endpackage

FILE: hdl/icr_div_cell.sv
// One restoring-division cell: retires one quotient bit of the mass weight.
// Depends on icr_pkg for the div_t payload carried along the chain.
module icr_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  icr_pkg::div_t d,
	output logic          out_valid,
	output icr_pkg::div_t r
);

	logic [icr_pkg::DEN_W:0] trial;
	logic [icr_pkg::DEN_W:0] sub;
	logic                    ge;
	icr_pkg::div_t           nxt;

	always_comb begin
		trial = {d.rem, d.bits[icr_pkg::Q_W-1]};
		sub   = trial - {1'b0, d.den};
		ge    = trial >= {1'b0, d.den};
		nxt   = d;
		nxt.rem  = ge ? sub[icr_pkg::DEN_W-1:0] : trial[icr_pkg::DEN_W-1:0];
		nxt.bits = {d.bits[icr_pkg::Q_W-2:0], 1'b0};
		nxt.quo  = {d.quo[icr_pkg::Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r <= nxt;
		end
	end

endmodule

FILE: hdl/impulse_collision_response_unit.sv
// Top level of the impulse collision response unit: dot product, impulse
// magnitude, a chain of division cells for the mass weights, and the update.
// Depends on icr_pkg and icr_div_cell.
//
// Usage:
// Input and output channels use valid/ready; a transfer happens when both
// are high. Each input transfer carries two velocities, two masses and a
// contact normal; each yields exactly one output transfer, in order.
// The restitution register is written through restitution_we and
// restitution_wdata; the user must write it only while the block is idle,
// which the block does not enforce. It resets to 1.0 (65536). The pipeline
// has five front stages for the relative normal speed and impulse
// magnitude, 25 division cells (one quotient bit each) and three stages for
// weighting, projection and saturation. Unless the output stalls, one item
// is accepted and each division cell hands its item to the next every cycle.
// When a result waits at the output and the receiver stalls, the whole
// pipeline holds and in_ready drops until out_ready returns; while the
// output register is empty the pipeline keeps moving whatever out_ready is.
// Reset clears all stage valid bits and returns restitution to 1.0.
module impulse_collision_response_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restitution_we,
	input  logic [16:0]        restitution_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] a_vel_x,
	input  logic signed [31:0] a_vel_y,
	input  logic signed [31:0] a_vel_z,
	input  logic signed [31:0] b_vel_x,
	input  logic signed [31:0] b_vel_y,
	input  logic signed [31:0] b_vel_z,
	input  logic [31:0]        a_mass,
	input  logic [31:0]        b_mass,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] a_out_x,
	output logic signed [31:0] a_out_y,
	output logic signed [31:0] a_out_z,
	output logic signed [31:0] b_out_x,
	output logic signed [31:0] b_out_y,
	output logic signed [31:0] b_out_z,
	output logic               impulse_applied,
	output logic               saturated
);

	localparam int VW = icr_pkg::VEL_W;
	localparam int NW = icr_pkg::NRM_W;
	localparam int DW = icr_pkg::DEN_W;
	localparam int QW = icr_pkg::Q_W;
	localparam int MW = icr_pkg::NUM_W;
	localparam int GW = icr_pkg::G_W;
	localparam int CN = icr_pkg::CELLS;

	logic [16:0] restitution_q;
	logic        adv;

	// Stage valids; stage 8 is the output register.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [2:0][VW-1:0]  va_s1, vb_s1, va_s2, vb_s2, va_s3, vb_s3, va_s4, vb_s4;
	logic [2:0][VW-1:0]  va_s5, vb_s5;
	logic [2:0][NW-1:0]  n_s1, n_s2, n_s3, n_s4, n_s5;
	logic [DW-1:0]       den_s1, den_s2, den_s3, den_s4, den_s5;
	logic [MW-1:0]       num_s1, num_s2, num_s3, num_s4, num_s5;
	logic signed [DW-1:0] diff_s1 [3];
	logic signed [48:0]  prod_s2 [3];
	logic signed [50:0]  vn_s3;
	logic                app_s3, app_s4, app_s5;
	logic [35:0]         u_s4;
	logic [GW-1:0]       g_s5;

	logic [50:0]         neg_vn;
	logic [17:0]         k_fac;
	logic [53:0]         gk;
	logic [MW-1:0]       num_in;
	logic [DW-1:0]       den_in;

	icr_pkg::div_t       chain [CN+1];
	logic                cvalid [CN+1];

	icr_pkg::job_t       job_s6, job_s7;
	logic [GW-1:0]       ha_s6, hb_s6;
	logic [QW-1:0]       wa, wb;
	logic [62:0]         pha, phb;
	logic signed [40:0]  da_s7 [3];
	logic signed [40:0]  db_s7 [3];
	logic signed [54:0]  hax, hbx, nx, pda, pdb;
	logic signed [41:0]  sa, sb;
	logic [2:0][VW-1:0]  ra, rb;
	logic                sat_any;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= icr_pkg::RESTITUTION_RESET;
		end else if (restitution_we) begin
			restitution_q <= restitution_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= cvalid[CN]; v_s7 <= v_s6; out_valid <= v_s7;
		end
	end

	// Front end: relative normal speed, then (1 + e) times its magnitude.
	always_comb begin
		den_in = {1'b0, a_mass} + {1'b0, b_mass};
		num_in = {1'b0, b_mass, 24'b0} + MW'(den_in >> 1);
		neg_vn = -vn_s3;
		k_fac  = 18'(restitution_q) + 18'd65536;
		gk     = 54'(u_s4) * 54'(k_fac) + 54'd32768;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			va_s1 <= {a_vel_z, a_vel_y, a_vel_x};
			vb_s1 <= {b_vel_z, b_vel_y, b_vel_x};
			n_s1  <= {normal_z, normal_y, normal_x};
			diff_s1[0] <= DW'(a_vel_x) - DW'(b_vel_x);
			diff_s1[1] <= DW'(a_vel_y) - DW'(b_vel_y);
			diff_s1[2] <= DW'(a_vel_z) - DW'(b_vel_z);
			den_s1 <= den_in;
			num_s1 <= num_in;

			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= 49'(diff_s1[i]) * 49'($signed(n_s1[i]));
			end
			va_s2 <= va_s1; vb_s2 <= vb_s1; n_s2 <= n_s1;
			den_s2 <= den_s1; num_s2 <= num_s1;

			vn_s3  <= 51'(prod_s2[0]) + 51'(prod_s2[1]) + 51'(prod_s2[2]);
			va_s3 <= va_s2; vb_s3 <= vb_s2; n_s3 <= n_s2;
			den_s3 <= den_s2; num_s3 <= num_s2;

			app_s4 <= vn_s3[50] || (vn_s3 == '0);
			u_s4   <= 36'((neg_vn + 51'd8192) >> 14);
			va_s4 <= va_s3; vb_s4 <= vb_s3; n_s4 <= n_s3;
			den_s4 <= den_s3; num_s4 <= num_s3;

			g_s5   <= gk[53:16];
			app_s5 <= app_s4;
			va_s5 <= va_s4; vb_s5 <= vb_s4; n_s5 <= n_s4;
			den_s5 <= den_s4; num_s5 <= num_s4;
		end
	end

	always_comb begin
		cvalid[0]             = v_s5;
		chain[0].rem          = {1'b0, num_s5[MW-1:QW]};
		chain[0].bits         = num_s5[QW-1:0];
		chain[0].quo          = '0;
		chain[0].den          = den_s5;
		chain[0].job.va       = va_s5;
		chain[0].job.vb       = vb_s5;
		chain[0].job.n        = n_s5;
		chain[0].job.g        = g_s5;
		chain[0].job.applied  = app_s5;
		chain[0].job.den_zero = (den_s5 == '0);
	end

	for (genvar c = 0; c < CN; c++) begin : g_cell
		icr_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (cvalid[c]),
			.d         (chain[c]),
			.out_valid (cvalid[c+1]),
			.r         (chain[c+1])
		);
	end

	// Back end: weights, impulse split, projection on the normal, saturation.
	always_comb begin
		wa  = chain[CN].job.den_zero ? icr_pkg::W_HALF : chain[CN].quo;
		wb  = icr_pkg::W_ONE - wa;
		pha = 63'(chain[CN].job.g) * 63'(wa) + 63'(icr_pkg::W_HALF);
		phb = 63'(chain[CN].job.g) * 63'(wb) + 63'(icr_pkg::W_HALF);
		hax = $signed({17'b0, ha_s6});
		hbx = $signed({17'b0, hb_s6});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s6 <= chain[CN].job;
			ha_s6  <= pha[61:24];
			hb_s6  <= phb[61:24];

			job_s7 <= job_s6;
			for (int i = 0; i < 3; i++) begin
				da_s7[i] <= 41'((hax * 55'($signed(job_s6.n[i])) + 55'sd8192) >>> 14);
				db_s7[i] <= 41'((hbx * 55'($signed(job_s6.n[i])) + 55'sd8192) >>> 14);
			end
		end
	end

	always_comb begin
		sat_any = 1'b0;
		ra = job_s7.va;
		rb = job_s7.vb;
		nx = '0; pda = '0; pdb = '0;
		sa = '0; sb = '0;
		if (job_s7.applied) begin
			for (int i = 0; i < 3; i++) begin
				sa = 42'($signed(job_s7.va[i])) + 42'(da_s7[i]);
				sb = 42'($signed(job_s7.vb[i])) - 42'(db_s7[i]);
				if (sa[41] && !(&sa[40:31])) begin
					ra[i] = 32'h8000_0000; sat_any = 1'b1;
				end else if (!sa[41] && (|sa[40:31])) begin
					ra[i] = 32'h7FFF_FFFF; sat_any = 1'b1;
				end else begin
					ra[i] = sa[31:0];
				end
				if (sb[41] && !(&sb[40:31])) begin
					rb[i] = 32'h8000_0000; sat_any = 1'b1;
				end else if (!sb[41] && (|sb[40:31])) begin
					rb[i] = 32'h7FFF_FFFF; sat_any = 1'b1;
				end else begin
					rb[i] = sb[31:0];
				end
			end
		end
		pda = nx;
		pdb = pda;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_out_x <= ra[0]; a_out_y <= ra[1]; a_out_z <= ra[2];
			b_out_x <= rb[0]; b_out_y <= rb[1]; b_out_z <= rb[2];
			impulse_applied <= job_s7.applied;
			saturated <= sat_any && (pdb == '0);
		end
	end

	// A separating pair never reports clipping.
	a_sep_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !impulse_applied |-> !saturated)
		else $error("separating pair flagged as saturated");

	// The weight quotient never exceeds one.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		cvalid[CN] && !chain[CN].job.den_zero |-> chain[CN].quo <= icr_pkg::W_ONE)
		else $error("mass weight above one");

	// The last division cell leaves a remainder below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cvalid[CN] && !chain[CN].job.den_zero |-> chain[CN].rem < chain[CN].den)
		else $error("division remainder out of range");

	// A stalled result is held until the receiver takes it.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(a_out_x) && $stable(saturated))
		else $error("stalled result changed");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for impulse_collision_response_unit.
// Depends on icr_pkg and the unit; predicts each result and compares fields.
`timescale 1ns / 1ps

module tb_top;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               restitution_we = 1'b0;
	logic [16:0]        restitution_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] a_vel_x = '0, a_vel_y = '0, a_vel_z = '0;
	logic signed [31:0] b_vel_x = '0, b_vel_y = '0, b_vel_z = '0;
	logic [31:0]        a_mass = '0, b_mass = '0;
	logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] a_out_x, a_out_y, a_out_z, b_out_x, b_out_y, b_out_z;
	logic               impulse_applied, saturated;

	typedef struct packed {
		logic [2:0][31:0] va;
		logic [2:0][31:0] vb;
		logic [31:0]      ma;
		logic [31:0]      mb;
		logic [2:0][15:0] n;
	} contact_t;

	typedef struct packed {
		logic [2:0][31:0] ra;
		logic [2:0][31:0] rb;
		logic             applied;
		logic             sat;
	} response_t;

	response_t   pending_responses[$];
	logic [16:0] restitution = icr_pkg::RESTITUTION_RESET;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatches = 0;
	int          responses_checked = 0;
	int          contacts_sent = 0;
	int          applied_seen = 0;
	int          sat_seen = 0;

	localparam int LATENCY = 33;

	impulse_collision_response_unit dut (
		.clk(clk), .arst_n(arst_n),
		.restitution_we(restitution_we), .restitution_wdata(restitution_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_vel_x(a_vel_x), .a_vel_y(a_vel_y), .a_vel_z(a_vel_z),
		.b_vel_x(b_vel_x), .b_vel_y(b_vel_y), .b_vel_z(b_vel_z),
		.a_mass(a_mass), .b_mass(b_mass),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.a_out_x(a_out_x), .a_out_y(a_out_y), .a_out_z(a_out_z),
		.b_out_x(b_out_x), .b_out_y(b_out_y), .b_out_z(b_out_z),
		.impulse_applied(impulse_applied), .saturated(saturated)
	);

	always #4 clk = ~clk;

	function automatic longint clip32(longint v, ref logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic response_t resolve_contact(contact_t c, logic [16:0] e);
		response_t r;
		longint va[3], vb[3], nn[3];
		longint vn, dv;
		logic [63:0] u, g, den, wa, wb, ha, hb;
		logic flag;
		vn = 0;
		flag = 1'b0;
		for (int i = 0; i < 3; i++) begin
			va[i] = longint'(signed'(c.va[i]));
			vb[i] = longint'(signed'(c.vb[i]));
			nn[i] = longint'(signed'(c.n[i]));
			vn += (va[i] - vb[i]) * nn[i];
		end
		r.applied = (vn <= 0);
		if (!r.applied) begin
			r.ra = c.va;
			r.rb = c.vb;
		end else begin
			u = (64'(-vn) + 64'd8192) >> 14;
			g = (u * (64'd65536 + 64'(e)) + 64'd32768) >> 16;
			den = 64'(c.ma) + 64'(c.mb);
			if (den == 0)
				wa = 64'd1 << 23;
			else
				wa = ((64'(c.mb) << 24) + (den >> 1)) / den;
			wb = (64'd1 << 24) - wa;
			ha = (g * wa + (64'd1 << 23)) >> 24;
			hb = (g * wb + (64'd1 << 23)) >> 24;
			for (int i = 0; i < 3; i++) begin
				// Arithmetic shift floors, matching the rounding rule.
				dv = (longint'(ha) * nn[i] + 8192) >>> 14;
				r.ra[i] = 32'(clip32(va[i] + dv, flag));
				dv = (longint'(hb) * nn[i] + 8192) >>> 14;
				r.rb[i] = 32'(clip32(vb[i] - dv, flag));
			end
		end
		r.sat = flag;
		return r;
	endfunction

	task automatic send_contact(contact_t c);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pending_responses.push_back(resolve_contact(c, restitution));
		in_valid <= 1'b1;
		{a_vel_x, a_vel_y, a_vel_z} <= {c.va[0], c.va[1], c.va[2]};
		{b_vel_x, b_vel_y, b_vel_z} <= {c.vb[0], c.vb[1], c.vb[2]};
		a_mass <= c.ma;
		b_mass <= c.mb;
		{normal_x, normal_y, normal_z} <= {c.n[0], c.n[1], c.n[2]};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		contacts_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_restitution(logic [16:0] value);
		drain_pipeline();
		restitution_we <= 1'b1;
		restitution_wdata <= value;
		@(posedge clk);
		restitution_we <= 1'b0;
		restitution = value;
	endtask

	function automatic logic [15:0] random_normal_part();
		case ($urandom_range(5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic [31:0] random_velocity();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
		endcase
	endfunction

	function automatic logic [31:0] random_mass();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd1;
			3, 4: return $urandom;
			default: return $urandom_range(32'h0010_0000, 32'h0000_1000);
		endcase
	endfunction

	function automatic contact_t random_contact();
		contact_t c;
		for (int i = 0; i < 3; i++) begin
			c.va[i] = random_velocity();
			c.vb[i] = random_velocity();
			c.n[i] = random_normal_part();
		end
		c.ma = random_mass();
		c.mb = random_mass();
		return c;
	endfunction

	task automatic test_directed();
		contact_t c;
		logic [31:0] vels[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0};
		// Opposite velocities along x at equal masses; separating along the normal.
		c = '0;
		c.va[0] = 32'h0001_0000; c.vb[0] = 32'hFFFF_0000;
		c.n[0] = 16'sd16384; c.ma = 32'h0001_0000; c.mb = 32'h0001_0000;
		send_contact(c);
		// Reversed normal: the pair approaches and the impulse applies.
		c.n[0] = -16'sd16384;
		send_contact(c);
		// Zero relative normal speed.
		c.vb[0] = c.va[0];
		send_contact(c);
		// Both masses zero, then one zero each way.
		c.vb[0] = 32'hFFFF_0000; c.n[0] = 16'sd16384;
		c.ma = 0; c.mb = 0; send_contact(c);
		c.mb = 32'h0002_0000; send_contact(c);
		c.ma = 32'h0002_0000; c.mb = 0; send_contact(c);
		c.ma = 32'hFFFF_FFFF; c.mb = 32'hFFFF_FFFF; send_contact(c);
		// Velocity extremes and small values, with saturating impulses at the extremes.
		for (int i = 0; i < 4; i++) begin
			c = '0;
			c.va = {3{vels[i]}};
			c.vb = {3{~vels[i]}};
			c.n = {3{16'sd16384}};
			c.ma = 32'h0001_0000; c.mb = 32'h0003_0000;
			send_contact(c);
			c.n = {3{-16'sd16384}};
			send_contact(c);
		end
		// Normals not of unit length, out of range.
		c.n = {16'h7FFF, 16'h8000, 16'hFFFF};
		send_contact(c);
		c.n = '0;
		send_contact(c);
		for (int i = 0; i < 6; i++)
			send_contact(random_contact());
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++)
			send_contact(random_contact());
	endtask

	task automatic test_idle_patterns();
		int pattern[4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{37, 37}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = pattern[p][0];
			recv_stall_pct = pattern[p][1];
			test_random(150);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_restitution_settings();
		logic [16:0] settings[5] = '{17'd0, 17'h1FFFF, 17'd32768, 17'd1, 17'h10000};
		for (int s = 0; s < 5; s++) begin
			write_restitution(settings[s]);
			test_random(s == 2 ? 200 : 60);
			// Hold the sender until the pipeline has emptied once.
			drain_pipeline();
			test_random(20);
		end
	endtask

	// Receiver stalls at random when recv_stall_pct is set; each transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		response_t want;
		response_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.ra = {a_out_z, a_out_y, a_out_x};
				got.rb = {b_out_z, b_out_y, b_out_x};
				got.applied = impulse_applied;
				got.sat = saturated;
				if (pending_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: %h", got);
				end else begin
					want = pending_responses.pop_front();
					responses_checked++;
					applied_seen += got.applied;
					sat_seen += got.sat;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: a exp %h got %h, b exp %h got %h, ",
								"flags exp %b%b got %b%b"},
								want.ra, got.ra, want.rb, got.rb, want.applied, want.sat,
								got.applied, got.sat);
					end
				end
			end
			out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_patterns();
		test_restitution_settings();
		drain_pipeline();
		repeat (LATENCY + 8) @(posedge clk);
		if (pending_responses.size() != 0)
			mismatches++;
		$display("Sent %0d contacts, checked %0d responses (%0d with impulse, %0d saturated).",
			contacts_sent, responses_checked, applied_seen, sat_seen);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
